// ===== rtl/plane_from_three_points_unit_assert.svh =====
// assertion macros for the plane unit, clocked on clk, disabled in rst
`ifndef PLANE_FROM_THREE_POINTS_UNIT_ASSERT_SVH
`define PLANE_FROM_THREE_POINTS_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds at every edge
`define PFP_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("plane unit check failed");
// antecedent now implies consequent in the next cycle
`define PFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("plane unit check failed");
`else
`define PFP_ASSERT(lbl, cond)
`define PFP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/pfp_pkg.sv =====
package pfp_pkg;

  // default coordinate width, signed Q8.16
  localparam int COORD_BITS_DEF = 24;

  // unit normal components, signed Q2.30
  localparam int NORM_W = 32;

  // quotient bits of c * 2^31 / s
  localparam int QUO_W = 32;

  // configuration register
  localparam logic [31:0] MIN_LEN_RESET = 32'd4294967;
  localparam logic REG_IDX_MIN_CROSS_LEN = 1'b0;

  // offset saturation limits
  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  // one result beat
  typedef struct packed {
    logic               plane_ok;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] offset;
  } plane_item_t;

endpackage

// ===== rtl/pfp_front.sv =====
module pfp_front import pfp_pkg::*; #(
  parameter int W  = COORD_BITS_DEF,
  parameter int MW = 2 * W + 1,
  parameter int LW = 4 * W + 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_v,
  input  logic [2:0][W-1:0]      p1,
  input  logic [2:0][W-1:0]      p2,
  input  logic [2:0][W-1:0]      p3,
  input  logic [31:0]            min_len,
  output logic                   out_v,
  output logic [LW-1:0]          len2,
  output logic                   ok,
  output logic [2:0]             sgn,
  output logic [2:0][MW-1:0]     mag,
  output logic [2:0][W-1:0]      p1_out
);

  localparam int DW  = W + 1;
  localparam int PW  = 2 * DW;
  localparam int HW  = (MW + 1) / 2;
  localparam int GW  = MW - HW;
  localparam int SQW = 2 * MW;
  localparam int NST = 7;

  logic [NST-1:0]          v;
  logic [2:0][W-1:0]       p1_d [NST];
  logic signed [DW-1:0]    a [3];
  logic signed [DW-1:0]    b [3];
  logic signed [PW-1:0]    pr [6];
  logic signed [PW-1:0]    cc [3];
  logic signed [PW-1:0]    ng [3];
  logic [2:0][MW-1:0]      mag_d [5];
  logic [2:0]              sgn_d [5];
  logic [2*GW-1:0]         hh [3];
  logic [MW-1:0]           hl [3];
  logic [2*HW-1:0]         ll [3];
  logic [63:0]             thr4;
  logic [SQW-1:0]          sq [3];
  logic [63:0]             thr5;
  logic [LW-1:0]           len6;
  logic [63:0]             thr6;
  logic [LW-1:0]           len7;
  logic                    ok7;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], in_v};
    end
  end

  // first point rides along to the end
  always_ff @(posedge clk) begin
    if (en) begin
      p1_d[0] <= p1;
      for (int k = 1; k < NST; k++) begin
        p1_d[k] <= p1_d[k-1];
      end
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a[i] <= {p3[i][W-1], p3[i]} - {p1[i][W-1], p1[i]};
        b[i] <= {p2[i][W-1], p2[i]} - {p1[i][W-1], p1[i]};
      end
    end
  end

  // stage 2: cross product terms
  always_ff @(posedge clk) begin
    if (en) begin
      pr[0] <= a[1] * b[2];
      pr[1] <= a[2] * b[1];
      pr[2] <= a[2] * b[0];
      pr[3] <= a[0] * b[2];
      pr[4] <= a[0] * b[1];
      pr[5] <= a[1] * b[0];
    end
  end

  // stage 3: cross product, split into sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cc[i] = pr[2*i] - pr[2*i+1];
      ng[i] = -cc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_d[0][i] <= cc[i][PW-1] ? ng[i][MW-1:0] : cc[i][MW-1:0];
        sgn_d[0][i] <= cc[i][PW-1];
      end
      for (int k = 1; k < 5; k++) begin
        mag_d[k] <= mag_d[k-1];
        sgn_d[k] <= sgn_d[k-1];
      end
    end
  end

  // stage 4: square partial products, threshold square
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mag_d[0][i][MW-1:HW] * mag_d[0][i][MW-1:HW];
        hl[i] <= mag_d[0][i][MW-1:HW] * mag_d[0][i][HW-1:0];
        ll[i] <= mag_d[0][i][HW-1:0] * mag_d[0][i][HW-1:0];
      end
      thr4 <= 64'(min_len) * 64'(min_len);
    end
  end

  // stage 5: per component squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SQW'(hh[i]) << (2 * HW)) + (SQW'(hl[i]) << (HW + 1)) + SQW'(ll[i]);
      end
      thr5 <= thr4;
    end
  end

  // stage 6: squared normal length
  always_ff @(posedge clk) begin
    if (en) begin
      len6 <= LW'(sq[0]) + LW'(sq[1]) + LW'(sq[2]);
      thr6 <= thr5;
    end
  end

  // stage 7: collinearity test
  always_ff @(posedge clk) begin
    if (en) begin
      len7 <= len6;
      ok7  <= (len6 >= LW'(thr6)) && (len6 != '0);
    end
  end

  assign out_v  = v[NST-1];
  assign len2   = len7;
  assign ok     = ok7;
  assign sgn    = sgn_d[4];
  assign mag    = mag_d[4];
  assign p1_out = p1_d[NST-1];

endmodule

// ===== rtl/pfp_sqrt.sv =====
module pfp_sqrt import pfp_pkg::*; #(
  parameter int LW  = 4 * COORD_BITS_DEF + 4,
  parameter int SW  = 2 * COORD_BITS_DEF + 2,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [LW-1:0]  rad,
  input  logic [SBW-1:0] sb,
  output logic           out_v,
  output logic [SW-1:0]  root,
  output logic [SBW-1:0] sb_out
);

  // one root bit per stage, remainder kept as radicand minus root squared
  logic [LW-1:0]  rem [SW];
  logic [SW-1:0]  rt  [SW];
  logic [SBW-1:0] sbq [SW];
  logic [SW-1:0]  v;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int B = SW - 1 - k;
    logic [LW-1:0]  rin;
    logic [SW-1:0]  qin;
    logic [SBW-1:0] sin;
    logic           vin;
    logic [LW-1:0]  trial;

    if (k == 0) begin : g_first
      assign rin = rad;
      assign qin = '0;
      assign sin = sb;
      assign vin = in_v;
    end else begin : g_next
      assign rin = rem[k-1];
      assign qin = rt[k-1];
      assign sin = sbq[k-1];
      assign vin = v[k-1];
    end

    // trial subtrahend 2*root*2^B + 4^B
    assign trial = (LW'(qin) << (B + 1)) | (LW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sbq[k] <= sin;
        if (rin >= trial) begin
          rem[k] <= rin - trial;
          rt[k]  <= qin | (SW'(1) << B);
        end else begin
          rem[k] <= rin;
          rt[k]  <= qin;
        end
      end
    end
  end

  assign out_v  = v[SW-1];
  assign root   = rt[SW-1];
  assign sb_out = sbq[SW-1];

endmodule

// ===== rtl/pfp_div.sv =====
module pfp_div import pfp_pkg::*; #(
  parameter int SW  = 2 * COORD_BITS_DEF + 2,
  parameter int MW  = 2 * COORD_BITS_DEF + 1,
  parameter int QW  = QUO_W,
  parameter int SBW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_v,
  input  logic [SW-1:0]      s,
  input  logic [2:0][MW-1:0] m,
  input  logic [SBW-1:0]     sb,
  output logic               out_v,
  output logic [2:0][QW-1:0] q,
  output logic [SBW-1:0]     sb_out
);

  // three restoring divider lanes share the divisor pipeline,
  // one quotient bit of m * 2^(QW-1) / s per stage
  logic [SW-1:0]  sq  [QW];
  logic [SBW-1:0] sbq [QW];
  logic [QW-1:0]  v;
  logic [SW-1:0]  r   [3][QW];
  logic [QW-1:0]  qq  [3][QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [SW-1:0]  sin;
    logic [SBW-1:0] bin;
    logic           vin;

    if (k == 0) begin : g_first
      assign sin = s;
      assign bin = sb;
      assign vin = in_v;
    end else begin : g_next
      assign sin = sq[k-1];
      assign bin = sbq[k-1];
      assign vin = v[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k]  <= sin;
        sbq[k] <= bin;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [SW:0]   t;
      logic [SW:0]   diff;
      logic [QW-1:0] qin;
      logic          ge;

      if (k == 0) begin : g_first
        // m never exceeds s, so the top quotient bit is the only one above
        assign t   = {1'b0, SW'(m[l])};
        assign qin = '0;
      end else begin : g_next
        assign t   = {r[l][k-1], 1'b0};
        assign qin = qq[l][k-1];
      end

      assign diff = t - {1'b0, sin};
      assign ge   = (t >= {1'b0, sin});

      always_ff @(posedge clk) begin
        if (en) begin
          r[l][k]  <= ge ? diff[SW-1:0] : t[SW-1:0];
          qq[l][k] <= {qin[QW-2:0], ge};
        end
      end
    end
  end

  assign out_v  = v[QW-1];
  assign sb_out = sbq[QW-1];
  assign q[0]   = qq[0][QW-1];
  assign q[1]   = qq[1][QW-1];
  assign q[2]   = qq[2][QW-1];

endmodule

// ===== rtl/pfp_back.sv =====
module pfp_back import pfp_pkg::*; #(
  parameter int W  = COORD_BITS_DEF,
  parameter int QW = QUO_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_v,
  input  logic               ok,
  input  logic [2:0]         sgn,
  input  logic [2:0][QW-1:0] q,
  input  logic [2:0][W-1:0]  p1,
  output logic               out_v,
  output plane_item_t        item
);

  localparam int PRW = NORM_W + W;
  localparam int TW  = NORM_W + W + 3;

  logic [2:0]               v;
  logic signed [NORM_W-1:0] n1 [3];
  logic [2:0][W-1:0]        p1_1;
  logic                     ok1;
  logic [QW:0]              inc [3];
  logic [NORM_W-1:0]        half [3];
  logic signed [NORM_W-1:0] n2 [3];
  logic signed [PRW-1:0]    pr [3];
  logic                     ok2;
  logic signed [TW-1:0]     dot;
  logic signed [TW-1:0]     e;
  logic signed [TW-1:0]     sh;
  logic                     fits;
  plane_item_t              res;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_v};
    end
  end

  // stage 1: round half away from zero, apply sign, zero when rejected
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inc[i]  = {1'b0, q[i]} + (QW + 1)'(1);
      half[i] = NORM_W'(inc[i][QW:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!ok) begin
          n1[i] <= '0;
        end else if (sgn[i]) begin
          n1[i] <= -$signed(half[i]);
        end else begin
          n1[i] <= $signed(half[i]);
        end
      end
      p1_1 <= p1;
      ok1  <= ok;
    end
  end

  // stage 2: normal times first point
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr[i] <= PRW'(n1[i]) * PRW'($signed(p1_1[i]));
        n2[i] <= n1[i];
      end
      ok2 <= ok1;
    end
  end

  // stage 3: negate, round, saturate the offset
  always_comb begin
    dot  = TW'(pr[0]) + TW'(pr[1]) + TW'(pr[2]);
    e    = -dot + (TW'(1) << 29);
    sh   = e >>> 30;
    fits = (&sh[TW-1:31]) | ~(|sh[TW-1:31]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.plane_ok <= ok2;
      res.normal_x <= n2[0];
      res.normal_y <= n2[1];
      res.normal_z <= n2[2];
      if (fits) begin
        res.offset <= sh[31:0];
      end else begin
        res.offset <= sh[TW-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  assign out_v = v[2];
  assign item  = res;

endmodule

// ===== rtl/plane_from_three_points_unit.sv =====
// Plane through three points: each input beat carries three signed Q8.16 points,
// each output beat the unit normal (Q2.30) of the plane through them and the
// offset d = -(n . p1) in Q16.16, saturating; a triple whose cross product is
// shorter than min_cross_len (register 0, Q.32) gives plane_ok = 0 and zeros.
// One triple is taken every cycle while in_stall is low; every step is its own
// stage. The path runs through 7 front stages, one stage per root bit in the
// square root, 32 divider stages, 3 back stages and the output register. An
// output register plus a skid entry sit at the end: in_stall rises only once
// both hold a beat, and the whole pipeline then holds until the skid entry
// drains.
`include "plane_from_three_points_unit_assert.svh"

module plane_from_three_points_unit import pfp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] p1_x,
  input  logic signed [COORD_BITS-1:0] p1_y,
  input  logic signed [COORD_BITS-1:0] p1_z,
  input  logic signed [COORD_BITS-1:0] p2_x,
  input  logic signed [COORD_BITS-1:0] p2_y,
  input  logic signed [COORD_BITS-1:0] p2_z,
  input  logic signed [COORD_BITS-1:0] p3_x,
  input  logic signed [COORD_BITS-1:0] p3_y,
  input  logic signed [COORD_BITS-1:0] p3_z,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         plane_ok,
  output logic signed [31:0]           normal_x,
  output logic signed [31:0]           normal_y,
  output logic signed [31:0]           normal_z,
  output logic signed [31:0]           offset,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int W    = COORD_BITS;
  localparam int MW   = 2 * W + 1;
  localparam int LW   = 4 * W + 4;
  localparam int SW   = 2 * W + 2;
  localparam int SB1W = 4 + 3 * MW + 3 * W;
  localparam int SB2W = 4 + 3 * W;

  logic [31:0]          min_cross_len;
  logic                 en;
  logic                 skid_valid;
  plane_item_t          out_item;
  plane_item_t          skid_item;

  logic [2:0][W-1:0]    p1_in;
  logic [2:0][W-1:0]    p2_in;
  logic [2:0][W-1:0]    p3_in;

  logic                 f_v;
  logic [LW-1:0]        f_len2;
  logic                 f_ok;
  logic [2:0]           f_sgn;
  logic [2:0][MW-1:0]   f_mag;
  logic [2:0][W-1:0]    f_p1;

  logic                 r_v;
  logic [SW-1:0]        r_root;
  logic [SB1W-1:0]      r_sb;
  logic                 r_ok;
  logic [2:0]           r_sgn;
  logic [2:0][MW-1:0]   r_mag;
  logic [2:0][W-1:0]    r_p1;

  logic                 d_v;
  logic [2:0][QUO_W-1:0] d_q;
  logic [SB2W-1:0]      d_sb;
  logic                 d_ok;
  logic [2:0]           d_sgn;
  logic [2:0][W-1:0]    d_p1;

  logic                 b_v;
  plane_item_t          b_item;
  logic                 take;

  logic                 all_zero;
  logic                 norm_in_range;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cross_len <= MIN_LEN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_MIN_CROSS_LEN)) begin
      min_cross_len <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_MIN_CROSS_LEN) ? min_cross_len : '0;

  // pipeline advances unless the skid entry is occupied
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  assign p1_in = {p1_z, p1_y, p1_x};
  assign p2_in = {p2_z, p2_y, p2_x};
  assign p3_in = {p3_z, p3_y, p3_x};

  pfp_front #(.W(W), .MW(MW), .LW(LW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (in_valid),
    .p1      (p1_in),
    .p2      (p2_in),
    .p3      (p3_in),
    .min_len (min_cross_len),
    .out_v   (f_v),
    .len2    (f_len2),
    .ok      (f_ok),
    .sgn     (f_sgn),
    .mag     (f_mag),
    .p1_out  (f_p1)
  );

  pfp_sqrt #(.LW(LW), .SW(SW), .SBW(SB1W)) u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (f_v),
    .rad    (f_len2),
    .sb     ({f_ok, f_sgn, f_mag, f_p1}),
    .out_v  (r_v),
    .root   (r_root),
    .sb_out (r_sb)
  );

  assign {r_ok, r_sgn, r_mag, r_p1} = r_sb;

  pfp_div #(.SW(SW), .MW(MW), .QW(QUO_W), .SBW(SB2W)) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (r_v),
    .s      (r_root),
    .m      (r_mag),
    .sb     ({r_ok, r_sgn, r_p1}),
    .out_v  (d_v),
    .q      (d_q),
    .sb_out (d_sb)
  );

  assign {d_ok, d_sgn, d_p1} = d_sb;

  pfp_back #(.W(W), .QW(QUO_W)) u_back (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (d_v),
    .ok    (d_ok),
    .sgn   (d_sgn),
    .q     (d_q),
    .p1    (d_p1),
    .out_v (b_v),
    .item  (b_item)
  );

  // output register with skid entry
  assign take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (b_v) begin
      if (!out_valid || take) begin
        out_item  <= b_item;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= b_item;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign plane_ok = out_item.plane_ok;
  assign normal_x = out_item.normal_x;
  assign normal_y = out_item.normal_y;
  assign normal_z = out_item.normal_z;
  assign offset   = out_item.offset;

  // terms for the checks
  assign all_zero = (normal_x == 32'sd0) && (normal_y == 32'sd0) &&
                    (normal_z == 32'sd0) && (offset == 32'sd0);
  assign norm_in_range = (normal_x <= 32'sd1073741824) && (normal_x >= -32'sd1073741824) &&
                         (normal_y <= 32'sd1073741824) && (normal_y >= -32'sd1073741824) &&
                         (normal_z <= 32'sd1073741824) && (normal_z >= -32'sd1073741824);

  // checks
  `PFP_ASSERT(a_skid_behind_out, !skid_valid || out_valid)
  `PFP_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid)
  `PFP_ASSERT(a_reject_zero, !out_valid || plane_ok || all_zero)
  `PFP_ASSERT(a_unit_range, !(out_valid && plane_ok) || norm_in_range)

endmodule
